>>> rtl/nce_pkg.sv
`default_nettype none
package nce_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_ORDER_DEF  = 4;

	// t = u * L and knot positions, Q.16 on the knot-interval scale
	localparam int TW = 24;
	// basis values, Q1.30
	localparam int BW = 31;
	localparam logic [BW-1:0] BASIS_ONE = 31'h4000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic REG_ORDER  = 1'b0;
	localparam logic REG_POINTS = 1'b1;

	typedef struct packed {
		logic start;
		logic full;
	} div_ctl_t;

	// knot j of the pinned uniform vector: clamp(j - d, 0, L) in units of 1.0
	function automatic logic [TW-1:0] knot_pos(input logic [8:0] j, input logic [2:0] d,
			input logic [6:0] len);
		logic signed [9:0] v;
		logic [6:0] c;
		v = $signed({1'b0, j}) - $signed({7'b0, d});
		if (v < 0) begin
			c = '0;
		end else if (v > $signed({3'b0, len})) begin
			c = len;
		end else begin
			c = v[6:0];
		end
		return {1'b0, c, 16'h0};
	endfunction

endpackage
`default_nettype wire

>>> rtl/nce_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Short mode assumes the
// quotient fits in 32 bits and skips the upper half.
module nce_div import nce_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_ctl_t    ctl,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic             done,
	output logic [63:0]      quo
);

	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [63:0] quo_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= ctl.full ? 6'd63 : 6'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q <= den;
			if (ctl.full) begin
				rem_q <= '0;
				quo_q <= num;
			end else begin
				rem_q <= num[63:32];
				quo_q <= {num[31:0], 32'h0};
			end
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

>>> rtl/nurbs_curve_point_eval_core.sv
`default_nettype none
// Rational B-spline curve evaluator on a pinned uniform knot vector. Opcode 0
// writes one control point (x, y, z, weight) and gives no word back; opcode 1
// evaluates the curve at param_u and returns one word. An evaluation runs the
// Cox-de Boor triangle and the three final quotients on a single bit-serial
// divider plus one shared multiplier; in_ready is low the whole time. After
// reset the weight table is cleared to 1.0 before the first item is taken.
// Config writes are taken at any time but must only be issued while the
// block is idle.
module nurbs_curve_point_eval_core import nce_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [5:0]  point_index,
	input  wire logic [31:0] coord_x_in,
	input  wire logic [31:0] coord_y_in,
	input  wire logic [31:0] coord_z_in,
	input  wire logic [15:0] weight_in,
	input  wire logic [16:0] param_u,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      point_x,
	output logic [31:0]      point_y,
	output logic [31:0]      point_z,
	output logic             eval_error
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NB = 2 * (MAX_ORDER - 1);
	localparam int RW = $clog2(NB);
	localparam int MW = 112;

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_SETUP = 5'd2;
	localparam logic [4:0] ST_SPAN  = 5'd3;
	localparam logic [4:0] ST_ENTRY = 5'd4;
	localparam logic [4:0] ST_TERM  = 5'd5;
	localparam logic [4:0] ST_DIVGO = 5'd6;
	localparam logic [4:0] ST_DIVW  = 5'd7;
	localparam logic [4:0] ST_STORE = 5'd8;
	localparam logic [4:0] ST_RD    = 5'd9;
	localparam logic [4:0] ST_WMUL  = 5'd10;
	localparam logic [4:0] ST_WSUM  = 5'd11;
	localparam logic [4:0] ST_PMUL  = 5'd12;
	localparam logic [4:0] ST_PACC  = 5'd13;
	localparam logic [4:0] ST_FGO   = 5'd14;
	localparam logic [4:0] ST_FW    = 5'd15;
	localparam logic [4:0] ST_DONE  = 5'd16;

	logic [4:0]          state_q;
	logic [2:0]          order_q;
	logic [6:0]          npts_q;
	logic [AW-1:0]       clr_q;
	logic [16:0]         u_q;
	logic [2:0]          deg_q;
	logic [6:0]          len_q;
	logic [TW-1:0]       t_q;
	logic [6:0]          span_q;
	logic [2:0]          lvl_q;
	logic [RW-1:0]       r_q;
	logic                tsel_q;
	logic [1:0]          axis_q;
	logic [BW-1:0]       b_q [NB];
	logic [32:0]         acc_q;
	logic [TW-1:0]       den_q;
	logic [28:0]         w_q;
	logic [31:0]         s_q;
	logic signed [63:0]  p_q [3];
	logic [31:0]         res_q [3];
	logic                rerr_q;
	logic signed [63:0]  prod_q;
	logic [MW-1:0]       mem [MAX_POINTS];
	logic [MW-1:0]       rd_q;

	logic                bad_cfg;
	logic [8:0]          i_c;
	logic [TW-1:0]       ki, k1, kk, kend;
	logic [TW-1:0]       den_f, den_g;
	logic [TW-1:0]       term_diff, term_den;
	logic [BW-1:0]       term_val;
	logic [RW-1:0]       rs_c;
	logic                out_c;
	logic                r_last;
	logic [TW-1:0]       t_c, tm1;
	logic [7:0]          seg_c;
	logic [6:0]          lim_c, sel_c, span_c;
	logic [63:0]         wsum_c;
	logic signed [32:0]  mul_a, mul_b;
	logic [31:0]         coord_c;
	logic signed [63:0]  p_sel;
	logic [63:0]         p_mag;
	logic [31:0]         sat_c;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [MW-1:0]       mem_wd;
	logic [AW-1:0]       rd_addr;
	div_ctl_t            div_ctl;
	logic [63:0]         div_num;
	logic [31:0]         div_den;
	logic                div_busy;
	logic                div_done;
	logic [63:0]         div_quo;

	assign bad_cfg = (order_q < 3'd2) || (32'(order_q) > MAX_ORDER)
		|| (32'(npts_q) > MAX_POINTS) || (npts_q < 7'(order_q));

	// knots around the current triangle entry, index i = span - d + r
	assign i_c   = 9'(span_q) - 9'(deg_q) + 9'(r_q);
	assign ki    = knot_pos(i_c, deg_q, len_q);
	assign k1    = knot_pos(i_c + 9'd1, deg_q, len_q);
	assign kk    = knot_pos(i_c + 9'(lvl_q), deg_q, len_q);
	assign kend  = knot_pos(i_c + 9'(lvl_q) + 9'd1, deg_q, len_q);
	assign den_f = kk - ki;
	assign den_g = kend - k1;
	assign out_c = (kend < t_q) || (ki > t_q);

	assign rs_c      = r_q + RW'(tsel_q);
	assign term_diff = tsel_q ? (kend - t_q) : (t_q - ki);
	assign term_den  = tsel_q ? den_g : den_f;
	assign term_val  = (lvl_q == 3'd1) ? BASIS_ONE : b_q[rs_c];

	assign r_last = 5'(r_q) == (5'({deg_q, 1'b0}) - 5'(lvl_q));

	// span = d + min(L-1, ceil(t)-1), d when t is zero
	assign t_c    = prod_q[TW-1:0];
	assign tm1    = t_c - TW'(1);
	assign seg_c  = (t_c == '0) ? 8'd0 : tm1[TW-1:16];
	assign lim_c  = len_q - 7'd1;
	assign sel_c  = (seg_c > {1'b0, lim_c}) ? lim_c : seg_c[6:0];
	assign span_c = 7'(deg_q) + sel_c;

	assign wsum_c = 64'(prod_q) + 64'd131072;

	always_comb begin
		case (axis_q)
			2'd0:    coord_c = rd_q[111:80];
			2'd1:    coord_c = rd_q[79:48];
			default: coord_c = rd_q[47:16];
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SETUP: begin
				mul_a = 33'(u_q);
				mul_b = 33'(len_q);
			end
			ST_TERM: begin
				mul_a = 33'(term_diff);
				mul_b = 33'(term_val);
			end
			ST_WMUL: begin
				mul_a = 33'(b_q[r_q]);
				mul_b = 33'(rd_q[15:0]);
			end
			ST_PMUL: begin
				mul_a = 33'(w_q);
				mul_b = {coord_c[31], coord_c};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a * mul_b);
	end

	assign p_sel = p_q[axis_q];
	assign p_mag = p_sel[63] ? (64'd0 - 64'(p_sel)) : 64'(p_sel);

	always_comb begin
		if (p_sel[63]) begin
			sat_c = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : div_quo[31:0];
			sat_c = 32'd0 - sat_c;
		end else begin
			sat_c = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	always_comb begin
		div_ctl = '0;
		div_num = '0;
		div_den = '0;
		if (state_q == ST_DIVGO) begin
			div_ctl.start = 1'b1;
			div_num = 64'(prod_q) + 64'(den_q >> 1);
			div_den = 32'(den_q);
		end else if (state_q == ST_FGO && s_q != '0) begin
			div_ctl.start = 1'b1;
			div_ctl.full  = 1'b1;
			div_num = p_mag + 64'(s_q >> 1);
			div_den = s_q;
		end
	end

	nce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// control point table: x, y, z, weight
	assign mem_we  = (state_q == ST_CLR) || (in_valid && in_ready && opcode == OP_WRITE
		&& 32'(point_index) < MAX_POINTS);
	assign mem_wa  = (state_q == ST_CLR) ? clr_q : AW'(point_index);
	assign mem_wd  = (state_q == ST_CLR) ? {96'h0, 16'd256}
		: {coord_x_in, coord_y_in, coord_z_in, weight_in};
	assign rd_addr = AW'(i_c);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			order_q    <= 3'd4;
			npts_q     <= 7'd4;
			clr_q      <= '0;
			u_q        <= '0;
			deg_q      <= '0;
			len_q      <= '0;
			t_q        <= '0;
			span_q     <= '0;
			lvl_q      <= '0;
			r_q        <= '0;
			tsel_q     <= 1'b0;
			axis_q     <= '0;
			acc_q      <= '0;
			den_q      <= '0;
			w_q        <= '0;
			s_q        <= '0;
			rerr_q     <= 1'b0;
			out_valid  <= 1'b0;
			point_x    <= '0;
			point_y    <= '0;
			point_z    <= '0;
			eval_error <= 1'b0;
			for (int n = 0; n < NB; n++) begin
				b_q[n] <= '0;
			end
			for (int n = 0; n < 3; n++) begin
				p_q[n]   <= '0;
				res_q[n] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ORDER:  order_q <= cfg_data[2:0];
					REG_POINTS: npts_q  <= cfg_data;
					default:    ;
				endcase
			end
			// the done state reloads the output itself
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_POINTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && opcode == OP_EVAL) begin
						u_q   <= (param_u > 17'h10000) ? 17'h10000 : param_u;
						deg_q <= order_q - 3'd1;
						len_q <= npts_q - 7'(order_q) + 7'd1;
						if (bad_cfg) begin
							rerr_q  <= 1'b1;
							res_q[0] <= '0;
							res_q[1] <= '0;
							res_q[2] <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					t_q     <= t_c;
					span_q  <= span_c;
					lvl_q   <= 3'd1;
					r_q     <= '0;
					state_q <= ST_ENTRY;
				end
				ST_ENTRY: begin
					if (out_c) begin
						acc_q   <= '0;
						state_q <= ST_STORE;
					end else if (lvl_q == 3'd1 && t_q == k1) begin
						acc_q   <= 33'(BASIS_ONE);
						state_q <= ST_STORE;
					end else begin
						acc_q   <= '0;
						// linear hat uses only the rising or the falling side
						tsel_q  <= (lvl_q == 3'd1) ? (t_q > k1) : 1'b0;
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (term_den == '0) begin
						if (!tsel_q && lvl_q != 3'd1) begin
							tsel_q <= 1'b1;
						end else begin
							state_q <= ST_STORE;
						end
					end else begin
						den_q   <= term_den;
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						acc_q <= acc_q + 33'(div_quo[31:0]);
						if (lvl_q != 3'd1 && !tsel_q) begin
							tsel_q  <= 1'b1;
							state_q <= ST_TERM;
						end else begin
							state_q <= ST_STORE;
						end
					end
				end
				ST_STORE: begin
					b_q[r_q] <= (acc_q > 33'(BASIS_ONE)) ? BASIS_ONE : acc_q[BW-1:0];
					if (r_last) begin
						r_q <= '0;
						if (lvl_q == deg_q) begin
							s_q     <= '0;
							p_q[0]  <= '0;
							p_q[1]  <= '0;
							p_q[2]  <= '0;
							state_q <= ST_RD;
						end else begin
							lvl_q   <= lvl_q + 3'd1;
							state_q <= ST_ENTRY;
						end
					end else begin
						r_q     <= r_q + RW'(1);
						state_q <= ST_ENTRY;
					end
				end
				ST_RD: begin
					state_q <= ST_WMUL;
				end
				ST_WMUL: begin
					state_q <= ST_WSUM;
				end
				ST_WSUM: begin
					w_q     <= wsum_c[46:18];
					s_q     <= s_q + 32'(wsum_c[46:18]);
					axis_q  <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= ST_PACC;
				end
				ST_PACC: begin
					p_q[axis_q] <= p_q[axis_q] + prod_q;
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						if (5'(r_q) == 5'(deg_q)) begin
							state_q <= ST_FGO;
						end else begin
							r_q     <= r_q + RW'(1);
							state_q <= ST_RD;
						end
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_PMUL;
					end
				end
				ST_FGO: begin
					if (s_q == '0) begin
						rerr_q   <= 1'b1;
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_FW;
					end
				end
				ST_FW: begin
					if (div_done) begin
						res_q[axis_q] <= sat_c;
						if (axis_q == 2'd2) begin
							rerr_q  <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= ST_FGO;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						point_x    <= res_q[0];
						point_y    <= res_q[1];
						point_z    <= res_q[2];
						eval_error <= rerr_q;
						out_valid  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// basis quotients never need the upper half of the divider
	a_short_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVW && div_done) |-> (div_quo[63:32] == '0))
		else $error("basis quotient overflowed 32 bits");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_busy)
		else $error("divider started while busy");

	a_span_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENTRY) |-> ((span_q >= 7'(deg_q)) && ((span_q - 7'(deg_q)) < len_q)))
		else $error("knot span out of range");

endmodule
`default_nettype wire

>>> sim/tb_nurbs_curve_point_eval_core.sv
`timescale 1ns / 1ps
module tb_nurbs_curve_point_eval_core;
	import nce_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int TARGET_ITEMS = 1350;

	typedef struct {
		logic        op;
		logic [5:0]  idx;
		logic [31:0] x, y, z;
		logic [15:0] w;
		logic [16:0] u;
	} cmd_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        err;
	} curve_pt_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0, cfg_index = 0;
	logic [6:0] cfg_data = 0;
	logic cfg_ready;
	logic in_valid = 0, in_ready;
	logic opcode = 0;
	logic [5:0] point_index = 0;
	logic [31:0] coord_x_in = 0, coord_y_in = 0, coord_z_in = 0;
	logic [15:0] weight_in = 0;
	logic [16:0] param_u = 0;
	logic out_valid, out_ready = 0;
	logic [31:0] point_x, point_y, point_z;
	logic eval_error;

	nurbs_curve_point_eval_core dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] tbl_x[64], tbl_y[64], tbl_z[64];
	logic [15:0] tbl_w[64];
	logic [2:0] order_reg = 4;
	logic [6:0] points_reg = 4;
	int cur_deg;
	longint cur_len;

	cmd_t pending_cmds[$];
	curve_pt_t expected_points[$];
	int items_total = 0, n_writes = 0, n_evals = 0, n_err_results = 0, n_phases = 0;
	int mismatches = 0;
	bit failed = 0;
	int unsigned cycles = 0;

	function automatic longint unsigned knot(int j);
		longint v;
		v = j - cur_deg;
		if (v < 0) v = 0;
		if (v > cur_len) v = cur_len;
		return longint'(v) * 65536;
	endfunction

	function automatic longint unsigned rnd_div(longint unsigned num, longint unsigned den);
		if (den == 0) return 0;
		return (num + den / 2) / den;
	endfunction

	function automatic longint unsigned basis_val(int i, int d, longint unsigned t);
		longint unsigned ki, kend, k1, k2, sf, sg, a, b, v;
		ki = knot(i);
		kend = knot(i + d + 1);
		a = 0;
		b = 0;
		if (kend < t || ki > t) return 0;
		if (d <= 1) begin
			k1 = knot(i + 1);
			k2 = knot(i + 2);
			if (t == k1) return longint'(BASIS_ONE);
			if (t < k1) return rnd_div((t - ki) * BASIS_ONE, k1 - ki);
			return rnd_div((k2 - t) * BASIS_ONE, k2 - k1);
		end
		sf = knot(i + d) - ki;
		sg = kend - knot(i + 1);
		if (sf != 0) a = rnd_div((t - ki) * basis_val(i, d - 1, t), sf);
		if (sg != 0) b = rnd_div((kend - t) * basis_val(i + 1, d - 1, t), sg);
		v = a + b;
		return v > BASIS_ONE ? longint'(BASIS_ONE) : v;
	endfunction

	// rational quotient, ties away from zero, saturated to 32 bits
	function automatic logic [31:0] coord_quot(longint p, longint unsigned s);
		longint unsigned mag;
		if (p < 0) begin
			mag = (longint'(0) - p + s / 2) / s;
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			return 32'(64'd0 - mag);
		end
		mag = (p + s / 2) / s;
		if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic curve_pt_t eval_point(logic [16:0] uin);
		curve_pt_t r;
		int ord, n, span;
		longint unsigned u, t, s, nb, w;
		longint px, py, pz;
		r = '{x: 0, y: 0, z: 0, err: 1};
		ord = order_reg;
		n = points_reg;
		s = 0;
		px = 0;
		py = 0;
		pz = 0;
		if (ord < 2 || ord > 4 || n > 64 || n < ord) return r;
		cur_deg = ord - 1;
		cur_len = n - ord + 1;
		u = uin > 65536 ? 65536 : uin;
		t = u * cur_len;
		span = ord - 1;
		for (int j = ord - 1; j <= n - 1; j++)
			if (knot(j) < t) span = j;
		for (int i = span; i > span - ord; i--) begin
			nb = basis_val(i, cur_deg, t);
			w = (nb * tbl_w[i] + (64'd1 << 17)) >> 18;
			s += w;
			px += longint'(w) * longint'($signed(tbl_x[i]));
			py += longint'(w) * longint'($signed(tbl_y[i]));
			pz += longint'(w) * longint'($signed(tbl_z[i]));
		end
		if (s == 0) return r;
		r.x = coord_quot(px, s);
		r.y = coord_quot(py, s);
		r.z = coord_quot(pz, s);
		r.err = 0;
		return r;
	endfunction

	// accept side: predictor runs on each accepted word
	bit in_fire = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			if (opcode == OP_WRITE) begin
				tbl_x[point_index] = coord_x_in;
				tbl_y[point_index] = coord_y_in;
				tbl_z[point_index] = coord_z_in;
				tbl_w[point_index] = weight_in;
			end else begin
				expected_points.push_back(eval_point(param_u));
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_points.size());
			$display("tb: failure");
			$finish;
		end
	end

	// driver: bursts with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		cmd_t c;
		logic nv;
		nv = in_valid && !in_fire;
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				opcode <= c.op;
				point_index <= c.idx;
				coord_x_in <= c.x;
				coord_y_in <= c.y;
				coord_z_in <= c.z;
				weight_in <= c.w;
				param_u <= c.u;
				nv = 1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
		end
		in_valid <= nv;
	end

	// receiver stall pattern, with a randomly chosen mode
	int rx_mode = 0;
	always @(negedge clk) begin
		if (cycles % 300 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		curve_pt_t e;
		if (out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word x=%h", point_x);
			end else begin
				e = expected_points.pop_front();
				if (eval_error) n_err_results++;
				if (point_x !== e.x || point_y !== e.y || point_z !== e.z ||
						eval_error !== e.err) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h err %b, got %h %h %h err %b",
							e.x, e.y, e.z, e.err, point_x, point_y, point_z, eval_error);
				end
			end
		end
	end

	task automatic cfg_write(logic idx, logic [6:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == REG_ORDER) order_reg = data[2:0];
		else points_reg = data;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_curve(int ord, int n);
		cfg_write(REG_ORDER, {4'($urandom), 3'(ord)});
		cfg_write(REG_POINTS, 7'(n));
		n_phases++;
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return $urandom_range(1, 16'hFFFF);
			default: return $urandom_range(64, 1024);
		endcase
	endfunction

	task automatic push_write(int idx, logic [15:0] w);
		cmd_t c;
		c = '{op: OP_WRITE, idx: 6'(idx), x: rand_coord(), y: rand_coord(), z: rand_coord(),
			w: w, u: 17'($urandom)};
		pending_cmds.push_back(c);
		items_total++;
		n_writes++;
	endtask

	task automatic push_eval(logic [16:0] u);
		cmd_t c;
		c = '{op: OP_EVAL, idx: 6'($urandom), x: $urandom, y: $urandom, z: $urandom,
			w: 16'($urandom), u: u};
		pending_cmds.push_back(c);
		items_total++;
		n_evals++;
	endtask

	function automatic logic [16:0] rand_param();
		int len, k;
		len = int'(points_reg) - int'(order_reg) + 1;
		if (len < 1) len = 1;
		k = $urandom_range(0, len);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 17'd65536;
			2: return $urandom_range(65537, 131071);
			3: return 17'((k * 65536) / len);
			4: return 17'((k * 65536) / len + 1);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	task automatic random_phase(int count);
		int n;
		n = points_reg > 64 ? 64 : points_reg;
		repeat (count) begin
			if ($urandom_range(0, 9) < 6)
				push_write(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, n - 1), rand_weight());
			else
				push_eval(rand_param());
		end
	endtask

	initial begin
		int ord, n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		for (int i = 0; i < 64; i++) begin
			tbl_w[i] = 256;
			tbl_x[i] = 0;
			tbl_y[i] = 0;
			tbl_z[i] = 0;
		end

		// fill the whole table so no unwritten entry is ever read
		for (int i = 0; i < 64; i++) push_write(i, $urandom_range(1, 16'hFFFF));
		push_eval(0);
		push_eval(17'd65536);
		push_eval(17'h1FFFF);
		push_eval(17'd32768);
		for (int i = 0; i < 4; i++) push_write(i, 16'h0000);
		push_eval(17'd40000);
		for (int i = 0; i < 4; i++) push_write(i, 16'h0100);
		push_eval(17'd20000);
		drain();

		// bad settings each give the error word
		set_curve(1, 4);
		push_eval(17'd100);
		drain();
		set_curve(5, 10);
		push_eval(17'd100);
		drain();
		set_curve(0, 127);
		push_eval(17'd100);
		drain();
		set_curve(4, 3);
		push_eval(17'd100);
		drain();
		set_curve(4, 65);
		push_eval(17'd100);
		drain();
		set_curve(7, 64);
		push_eval(17'd100);
		drain();

		set_curve(2, 2);
		random_phase(30);
		drain();
		set_curve(4, 64);
		random_phase(20);
		// sender holds off until every result is back
		while (pending_cmds.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		random_phase(20);
		drain();

		while (items_total < TARGET_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				set_curve($urandom_range(0, 7), $urandom_range(0, 127));
				random_phase($urandom_range(2, 6));
			end else begin
				ord = $urandom_range(2, 4);
				n = ($urandom_range(0, 1) == 0) ? $urandom_range(ord, 8)
					: $urandom_range(ord, 64);
				set_curve(ord, n);
				random_phase($urandom_range(30, 80));
			end
			drain();
		end

		repeat (1200) @(posedge clk);
		if (expected_points.size() != 0) begin
			failed = 1;
			$display("%0d expected results never arrived", expected_points.size());
		end
		$display("covered %0d items (%0d table writes, %0d evaluations) over %0d settings",
			items_total, n_writes, n_evals, n_phases);
		$display("%0d error results seen, %0d mismatches", n_err_results, mismatches);
		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/nce_pkg.sv
rtl/nce_div.sv
rtl/nurbs_curve_point_eval_core.sv
sim/tb_nurbs_curve_point_eval_core.sv
